// ===== sv/ssi_pkg.sv =====
package ssi_pkg;
  // The valid and hit flags travel together; payload widths follow the top-level parameters.
  typedef struct packed {
    logic valid;
    logic hit;
  } ssi_ctl_t;
endpackage

// ===== sv/segment_segment_intersection_core.sv =====
// An accepted start passes the difference, product, sum and range stages, then the divider stages, to the done strobe.
// Throughput: one segment pair per cycle; busy is held low at all times.
// The fraction dividers are unrolled one quotient bit per pipeline stage.
// Reset (rst, synchronous) clears every stage valid bit; no results follow until start.
// The receiver cannot stall, so results leave on done for exactly one cycle.
module segment_segment_intersection_core #(
  parameter int COORD_WIDTH   = 16,
  parameter int FRACTION_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] a_start_x,
  input  logic signed [COORD_WIDTH-1:0] a_start_y,
  input  logic signed [COORD_WIDTH-1:0] a_end_x,
  input  logic signed [COORD_WIDTH-1:0] a_end_y,
  input  logic signed [COORD_WIDTH-1:0] b_start_x,
  input  logic signed [COORD_WIDTH-1:0] b_start_y,
  input  logic signed [COORD_WIDTH-1:0] b_end_x,
  input  logic signed [COORD_WIDTH-1:0] b_end_y,
  output logic                          done,
  output logic                          hit,
  output logic [FRACTION_BITS:0]        t_along_a,
  output logic [FRACTION_BITS:0]        u_along_b
);
  import ssi_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int MW = SW;
  localparam int QW = FRACTION_BITS + 1;
  localparam int NS = FRACTION_BITS + 1;

  // Stage 1: differences.
  logic                 v1;
  logic signed [DW-1:0] dax, day, dbx, dby, wx, wy;
  // Stage 2: products.
  logic                 v2;
  logic signed [PW-1:0] p_den0, p_den1, p_tn0, p_tn1, p_un0, p_un1;
  // Stage 3: sums.
  logic                 v3;
  logic signed [SW-1:0] den, tn, un;
  // Stage 4: range test and magnitudes.
  ssi_ctl_t             c4;
  logic [MW-1:0]        mden, mtn, mun;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
    dax <= DW'(a_end_x) - DW'(a_start_x);
    day <= DW'(a_end_y) - DW'(a_start_y);
    dbx <= DW'(b_end_x) - DW'(b_start_x);
    dby <= DW'(b_end_y) - DW'(b_start_y);
    wx  <= DW'(b_start_x) - DW'(a_start_x);
    wy  <= DW'(b_start_y) - DW'(a_start_y);
    p_den0 <= PW'(dax) * PW'(dby);
    p_den1 <= PW'(day) * PW'(dbx);
    p_tn0  <= PW'(wx) * PW'(dby);
    p_tn1  <= PW'(wy) * PW'(dbx);
    p_un0  <= PW'(wx) * PW'(day);
    p_un1  <= PW'(wy) * PW'(dax);
    den <= SW'(p_den0) - SW'(p_den1);
    tn  <= SW'(p_tn0) - SW'(p_tn1);
    un  <= SW'(p_un0) - SW'(p_un1);
  end

  logic [MW-1:0] mden_c, mtn_c, mun_c;
  logic          t_in, u_in;
  always_comb begin
    mden_c = den[SW-1] ? MW'(-den) : MW'(den);
    mtn_c  = tn[SW-1] ? MW'(-tn) : MW'(tn);
    mun_c  = un[SW-1] ? MW'(-un) : MW'(un);
    t_in = (tn == '0) || ((tn[SW-1] == den[SW-1]) && (mtn_c <= mden_c));
    u_in = (un == '0) || ((un[SW-1] == den[SW-1]) && (mun_c <= mden_c));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c4.valid <= 1'b0;
    end else begin
      c4.valid <= v3;
    end
    c4.hit <= (den != '0) && t_in && u_in;
    mden   <= mden_c;
    mtn    <= mtn_c;
    mun    <= mun_c;
  end

  // Divider stages: each produces one quotient bit for t and one for u.
  ssi_ctl_t      sc [NS+1];
  logic [MW-1:0] sd [NS+1];
  logic [MW:0]   rt [NS+1];
  logic [MW:0]   ru [NS+1];
  logic [QW-1:0] qt [NS+1];
  logic [QW-1:0] qu [NS+1];

  assign sc[0] = c4;
  assign sd[0] = mden;
  assign rt[0] = {1'b0, mtn};
  assign ru[0] = {1'b0, mun};
  assign qt[0] = '0;
  assign qu[0] = '0;

  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [MW:0] tr, ur;
    logic        tb, ub;
    always_comb begin
      tr = (k == 0) ? rt[k] : {rt[k][MW-1:0], 1'b0};
      ur = (k == 0) ? ru[k] : {ru[k][MW-1:0], 1'b0};
      tb = tr >= {1'b0, sd[k]};
      ub = ur >= {1'b0, sd[k]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sc[k+1].valid <= 1'b0;
      end else begin
        sc[k+1].valid <= sc[k].valid;
      end
      sc[k+1].hit <= sc[k].hit;
      sd[k+1]     <= sd[k];
      rt[k+1]     <= tb ? tr - {1'b0, sd[k]} : tr;
      ru[k+1]     <= ub ? ur - {1'b0, sd[k]} : ur;
      qt[k+1]     <= {qt[k][QW-2:0], tb};
      qu[k+1]     <= {qu[k][QW-2:0], ub};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sc[NS].valid;
    end
    hit       <= sc[NS].hit;
    t_along_a <= sc[NS].hit ? qt[NS] : '0;
    u_along_b <= sc[NS].hit ? qu[NS] : '0;
  end

`ifndef ASSERT_OFF
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    c4.valid |-> ##(NS+1) done)
    else $error("result lost in divider pipeline");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (t_along_a == '0 && u_along_b == '0))
    else $error("fractions nonzero on a miss");
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (t_along_a <= (QW'(1) << FRACTION_BITS)
              && u_along_b <= (QW'(1) << FRACTION_BITS)))
    else $error("fraction above one");
  a_hit_nonzero_den: assert property (@(posedge clk) disable iff (rst)
    (c4.valid && c4.hit) |-> (mden != '0))
    else $error("hit with zero denominator");
`endif
endmodule
